@@ hw/rtl/chpc_pkg.sv @@
// Shared types, codes and functions of the container header packet checker.
`default_nettype none

package chpc_pkg;

  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;

  localparam logic [63:0] SC_MAIN      = 64'h4E4D_7A56_1F5F_04AD;
  localparam logic [63:0] SC_STREAM    = 64'h4E53_1140_5BF2_F9DB;
  localparam logic [63:0] SC_SYNCPOINT = 64'h4E4B_E4AD_EECA_4569;
  localparam logic [63:0] SC_INDEX     = 64'h4E58_DD67_2F23_E64E;
  localparam logic [63:0] SC_INFO      = 64'h4E49_AB68_B596_BA78;

  localparam logic [3:0] STARTCODE_BYTES = 4'd8;
  localparam logic [3:0] HDR_CRC_BYTES   = 4'd4;

  localparam logic CFG_HDR_THRESHOLD = 1'b0;
  localparam logic CFG_MAX_LENGTH    = 1'b1;

  typedef enum logic [2:0] {
    KIND_MAIN      = 3'd0,
    KIND_STREAM    = 3'd1,
    KIND_SYNCPOINT = 3'd2,
    KIND_INDEX     = 3'd3,
    KIND_INFO      = 3'd4,
    KIND_UNKNOWN   = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_HDR_CRC_BAD = 3'd1,
    ST_PKT_CRC_BAD = 3'd2,
    ST_LEN_LARGE   = 3'd3,
    ST_END_HEADERS = 3'd4
  } status_t;

  // One byte of the stream as held in the input register.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } item_t;

  typedef struct packed {
    logic [31:0] header_crc_threshold;
    logic [31:0] max_packet_length;
  } cfg_t;

  // One verdict word.
  typedef struct packed {
    logic        valid;
    kind_t       kind;
    status_t     status;
    logic [31:0] length;
  } res_t;

  // MSB-first CRC-32 update over one byte.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'd0};
    for (int i = 0; i < 8; i++) begin
      c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
    end
    return c;
  endfunction

  function automatic kind_t classify(input logic [63:0] sc);
    kind_t k;
    if (sc == SC_MAIN) k = KIND_MAIN;
    else if (sc == SC_STREAM) k = KIND_STREAM;
    else if (sc == SC_SYNCPOINT) k = KIND_SYNCPOINT;
    else if (sc == SC_INDEX) k = KIND_INDEX;
    else if (sc == SC_INFO) k = KIND_INFO;
    else k = KIND_UNKNOWN;
    return k;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/container_header_packet_checker_top.sv @@
// Top level of the container header packet checker.
//
// The input channel carries one stream byte per word (data_byte) with a
// restart flag that clears the parse state and makes this byte the first
// startcode byte. The output channel carries one verdict word per packet:
// packet kind, status and the forward length that was read. Both channels
// use valid and stall; a word moves on an edge where valid is high and stall
// is low. The configuration port writes the header CRC threshold (index 0)
// or the maximum packet length (index 1) on any edge with cfg_we high, and is
// meant to be used only while the block is idle.
//
// An accepted byte waits in the input register until the output register can
// advance; at that edge the parser updates its state and loads any verdict
// into the output register. The verdict word is valid from that edge on.
// The block takes one byte every cycle while the receiver does not stall, and
// the rate is set by the combinational CRC byte update. While the receiver
// stalls a held verdict, nothing leaves the input register: one more byte is
// taken only if that register is empty, and in_stall stays high until the
// verdict leaves. Reset clears the parse state, empties both registers and
// restores the register defaults. After an error or end-of-headers verdict,
// bytes are dropped until restart.
`default_nettype none

module container_header_packet_checker_top
  import chpc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        restart,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       packet_kind,
  output logic [2:0]       status,
  output logic [31:0]      packet_length,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  cfg_t  cfg;
  item_t item;
  res_t  res;
  logic  step;
  logic  advance;

  chpc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  chpc_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .restart   (restart),
    .advance   (advance),
    .step      (step),
    .item      (item)
  );

  chpc_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (item),
    .cfg  (cfg),
    .res  (res)
  );

  chpc_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .res           (res),
    .advance       (advance),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .packet_kind   (packet_kind),
    .status        (status),
    .packet_length (packet_length)
  );

endmodule

`default_nettype wire

@@ hw/rtl/chpc_cfg.sv @@
// Configuration registers of the container header packet checker.
`default_nettype none

module chpc_cfg
  import chpc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  output cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_crc_threshold <= 32'd4096;
      cfg.max_packet_length    <= 32'hFFFF_FFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HDR_THRESHOLD: cfg.header_crc_threshold <= cfg_data;
        CFG_MAX_LENGTH:    cfg.max_packet_length    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/chpc_in_stage.sv @@
// Input register that holds one accepted stream word until the parser takes it.
`default_nettype none

module chpc_in_stage
  import chpc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] data_byte,
  input  wire logic       restart,
  input  wire logic       advance,
  output logic            step,
  output item_t           item
);

  logic held;

  assign in_stall = held && !advance;
  assign step     = held && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (!in_stall) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item.data_byte <= data_byte;
      item.restart   <= restart;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/chpc_parse.sv @@
// Packet parser: startcode, length, header CRC and payload CRC state.
`default_nettype none

module chpc_parse
  import chpc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  step,
  input  wire item_t item,
  input  wire cfg_t  cfg,
  output res_t       res
);

  typedef enum logic [4:0] {
    PH_START = 5'b00001,
    PH_LEN   = 5'b00010,
    PH_HDR   = 5'b00100,
    PH_PAY   = 5'b01000,
    PH_HALT  = 5'b10000
  } phase_t;

  phase_t      phase, phase_next, ph;
  logic [3:0]  byte_counter, byte_counter_next, bc;
  logic [63:0] startcode_shift, startcode_shift_next, sc;
  logic [31:0] length_accumulator, length_accumulator_next, acc;
  logic        length_overflow, length_overflow_next, ovf;
  logic [31:0] bytes_remaining, bytes_remaining_next, rem;
  logic [31:0] crc_register, crc_register_next, crc;
  kind_t       kind_register, kind_register_next, kind;
  logic        begin_pay;
  logic [7:0]  b;

  always_comb begin
    b = item.data_byte;
    // A restart clears the parse state before this byte is taken.
    ph   = item.restart ? PH_START : phase;
    bc   = item.restart ? 4'd0 : byte_counter;
    sc   = item.restart ? 64'd0 : startcode_shift;
    acc  = item.restart ? 32'd0 : length_accumulator;
    ovf  = item.restart ? 1'b0 : length_overflow;
    rem  = item.restart ? 32'd0 : bytes_remaining;
    crc  = item.restart ? 32'd0 : crc_register;
    kind = item.restart ? KIND_MAIN : kind_register;

    phase_next              = ph;
    byte_counter_next       = bc;
    startcode_shift_next    = sc;
    length_accumulator_next = acc;
    length_overflow_next    = ovf;
    bytes_remaining_next    = rem;
    crc_register_next       = crc;
    kind_register_next      = kind;
    begin_pay               = 1'b0;
    res.valid  = 1'b0;
    res.status = ST_OK;
    res.length = 32'd0;

    case (ph)
      PH_START: begin
        crc_register_next    = crc_byte((bc == 4'd0) ? 32'd0 : crc, b);
        startcode_shift_next = {sc[55:0], b};
        byte_counter_next    = bc + 4'd1;
        if (byte_counter_next == STARTCODE_BYTES) begin
          byte_counter_next  = 4'd0;
          kind_register_next = classify(startcode_shift_next);
          if (kind_register_next == KIND_SYNCPOINT || kind_register_next == KIND_INDEX) begin
            phase_next = PH_HALT;
            res.valid  = 1'b1;
            res.status = ST_END_HEADERS;
          end else begin
            length_accumulator_next = 32'd0;
            length_overflow_next    = 1'b0;
            phase_next              = PH_LEN;
          end
        end
      end
      PH_LEN: begin
        crc_register_next = crc_byte(crc, b);
        if (acc[31:25] != 7'd0) begin
          length_overflow_next = 1'b1;
        end
        length_accumulator_next = {acc[24:0], b[6:0]};
        if (!b[7]) begin
          if (length_overflow_next) begin
            phase_next = PH_HALT;
            res.valid  = 1'b1;
            res.status = ST_LEN_LARGE;
            res.length = 32'hFFFF_FFFF;
          end else if (length_accumulator_next > cfg.max_packet_length) begin
            phase_next = PH_HALT;
            res.valid  = 1'b1;
            res.status = ST_LEN_LARGE;
            res.length = length_accumulator_next;
          end else if (length_accumulator_next > cfg.header_crc_threshold) begin
            byte_counter_next = 4'd0;
            phase_next        = PH_HDR;
          end else begin
            begin_pay = 1'b1;
          end
        end
      end
      PH_HDR: begin
        crc_register_next = crc_byte(crc, b);
        byte_counter_next = bc + 4'd1;
        if (byte_counter_next == HDR_CRC_BYTES) begin
          byte_counter_next = 4'd0;
          if (crc_register_next != 32'd0) begin
            phase_next = PH_HALT;
            res.valid  = 1'b1;
            res.status = ST_HDR_CRC_BAD;
            res.length = acc;
          end else begin
            begin_pay = 1'b1;
          end
        end
      end
      PH_PAY: begin
        crc_register_next    = crc_byte(crc, b);
        bytes_remaining_next = rem - 32'd1;
        if (bytes_remaining_next == 32'd0) begin
          byte_counter_next = 4'd0;
          res.valid  = 1'b1;
          res.length = acc;
          if (crc_register_next != 32'd0) begin
            phase_next = PH_HALT;
            res.status = ST_PKT_CRC_BAD;
          end else begin
            phase_next = PH_START;
          end
        end
      end
      default: ;
    endcase

    // Payload entry: an empty packet is finished right here.
    if (begin_pay) begin
      if (length_accumulator_next == 32'd0) begin
        phase_next        = PH_START;
        byte_counter_next = 4'd0;
        res.valid         = 1'b1;
      end else begin
        bytes_remaining_next = length_accumulator_next;
        crc_register_next    = 32'd0;
        phase_next           = PH_PAY;
      end
    end

    res.kind = kind_register_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_START;
      byte_counter       <= 4'd0;
      startcode_shift    <= 64'd0;
      length_accumulator <= 32'd0;
      length_overflow    <= 1'b0;
      bytes_remaining    <= 32'd0;
      crc_register       <= 32'd0;
      kind_register      <= KIND_MAIN;
    end else if (step) begin
      phase              <= phase_next;
      byte_counter       <= byte_counter_next;
      startcode_shift    <= startcode_shift_next;
      length_accumulator <= length_accumulator_next;
      length_overflow    <= length_overflow_next;
      bytes_remaining    <= bytes_remaining_next;
      crc_register       <= crc_register_next;
      kind_register      <= kind_register_next;
    end
  end

  a_end_kind: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status == ST_END_HEADERS) |->
      (res.kind == KIND_SYNCPOINT || res.kind == KIND_INDEX))
    else $error("end of headers reported for a non-terminating startcode");

  a_halt_after_error: assert property (@(posedge clk) disable iff (rst)
    (step && res.valid && res.status != ST_OK) |=> (phase == PH_HALT))
    else $error("parser did not halt after a failing verdict");

  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HALT && !item.restart) |-> !res.valid)
    else $error("halted parser produced a verdict");

endmodule

`default_nettype wire

@@ hw/rtl/chpc_out_reg.sv @@
// Output register that holds one verdict word until the receiver takes it.
`default_nettype none

module chpc_out_reg
  import chpc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   step,
  input  wire res_t   res,
  output logic        advance,
  output logic        out_valid,
  input  wire logic   out_stall,
  output logic [2:0]  packet_kind,
  output logic [2:0]  status,
  output logic [31:0] packet_length
);

  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step && res.valid) begin
      packet_kind   <= res.kind;
      status        <= res.status;
      packet_length <= res.length;
    end
  end

endmodule

`default_nettype wire
